// ===== rtl/core/cone_mesh_vertex_generator_macros.svh =====
// assertion macros shared by the cone mesh vertex generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CONE_MESH_VERTEX_GENERATOR_MACROS_SVH
`define CONE_MESH_VERTEX_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CMVG_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CMVG_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cmvg_pkg.sv =====
// types, constants and helper functions for the cone mesh vertex generator
// no dependencies; used by the channel interfaces and the top level
package cmvg_pkg;

  localparam int MAX_SLICES   = 1024;
  localparam int MAX_STACKS   = 1024;
  localparam int SINE_DEPTH   = 256;
  localparam int ANGLE_BITS   = 16;

  localparam int CNT_W        = 11;  // slice and stack counts
  localparam int IDX_W        = 10;  // slice and stack indices
  localparam int LEN_W        = 16;  // q8.8 lengths
  localparam int CFG_W        = 16;  // widest register
  localparam int CFG_IDX_W    = 2;

  localparam int DIV_NUM_W    = 27;
  localparam int DIV_Q_W      = 17;
  localparam int DIV_REM_W    = CNT_W;
  localparam int DIV_STEPS    = DIV_Q_W;

  localparam int NORM_FRAC    = 14;
  localparam int MAG_W        = 15;  // q1.14 magnitude up to 1.0
  localparam int TEX_W        = 17;
  localparam int SINE_IDX_W   = 9;
  localparam int SINE_SHIFT   = ANGLE_BITS - 2 - 8;

  localparam int CU_QUOT_W    = 29;
  localparam int CU_ROOT_STEPS = 15;
  localparam int CU_STEP_W    = 5;

  localparam logic [MAG_W-1:0]        ONE_Q14   = MAG_W'(16384);
  localparam logic signed [15:0]      NORM_DOWN = -16'sd16384;
  localparam logic [TEX_W-1:0]        TEX_ONE   = TEX_W'(65536);
  localparam logic [TEX_W-1:0]        TEX_HALF  = TEX_W'(32768);
  localparam logic [ANGLE_BITS-1:0]   QUARTER_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  localparam longint unsigned         PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_HEIGHT,
    REG_SLICES,
    REG_STACKS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VK_SIDE,
    VK_RIM,
    VK_CENTRE,
    VK_BAD
  } vkind_t;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_SQUARE,
    CU_SETUP,
    CU_DIV,
    CU_ROOT
  } cu_state_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_Q_W-1:0]   w;    // numerator bits in, quotient bits out
  } div_lane_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  typedef logic [MAG_W-1:0] sine_tab_t [SINE_DEPTH+1];

  // quarter-wave sine in q1.14, taylor series in q30
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = PI_HALF_Q30 * longint'(i) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if (n == 1 || n == 3 || n == 5) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd32768) >> 16;
      if (v > 64'(ONE_Q14)) begin
        v = 64'(ONE_Q14);
      end
      tab[i] = MAG_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic sine_t sine_of(input logic [ANGLE_BITS-1:0] phase);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] f;
    logic [SINE_IDX_W-1:0] idx;
    sine_t                 s;
    quad = phase[ANGLE_BITS-1 -: 2];
    f    = phase[ANGLE_BITS-3:0];
    idx  = SINE_IDX_W'((ANGLE_BITS'(f) + ANGLE_BITS'(1 << (SINE_SHIFT - 1))) >> SINE_SHIFT);
    if (quad[0]) begin
      idx = SINE_IDX_W'(SINE_DEPTH) - idx;
    end
    s.mag = SINE_TAB[idx];
    s.neg = quad[1] && (s.mag != '0);
    return s;
  endfunction

  function automatic div_lane_t div_init(input logic [DIV_NUM_W-1:0] n);
    div_lane_t y;
    y.rem = {1'b0, n[DIV_NUM_W-1:DIV_Q_W]};
    y.w   = n[DIV_Q_W-1:0];
    return y;
  endfunction

  // one restoring division step, one quotient bit
  function automatic div_lane_t div_step(input div_lane_t x, input logic [CNT_W-1:0] d);
    logic [DIV_REM_W:0] t;
    logic               ge;
    div_lane_t          y;
    t     = {x.rem, x.w[DIV_Q_W-1]};
    ge    = (t >= {1'b0, d});
    y.rem = ge ? DIV_REM_W'(t - {1'b0, d}) : t[DIV_REM_W-1:0];
    y.w   = {x.w[DIV_Q_W-2:0], ge};
    return y;
  endfunction

endpackage

// ===== rtl/core/cmvg_if.sv =====
// request and vertex channel interfaces of the cone mesh vertex generator
// depends on cmvg_pkg for field widths
interface cmvg_req_if import cmvg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] slice_index;
  logic [IDX_W-1:0] stack_index;

  modport source (output valid, func, slice_index, stack_index, input ready);
  modport sink   (input valid, func, slice_index, stack_index, output ready);
endinterface

interface cmvg_vtx_if import cmvg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LEN_W:0]   pos_x;
  logic [LEN_W-1:0]        pos_y;
  logic signed [LEN_W:0]   pos_z;
  logic signed [15:0]      norm_x;
  logic signed [15:0]      norm_y;
  logic signed [15:0]      norm_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic                    bad_index;
  logic                    last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, bad_index, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, bad_index, last_vertex, output ready);
endinterface

// ===== rtl/core/cone_mesh_vertex_generator.sv =====
// top level of the cone mesh vertex generator: request expander, vertex pipeline
// and normal-scale unit; depends on cmvg_pkg, cmvg_if.sv and the macros header
//
//  channel   dir  word                               handshake
//  req       in   func, slice_index, stack_index     valid / ready
//  vtx       out  one vertex (position, normal, uv)  valid / ready
//  cfg       in   cfg_index, cfg_data                cfg_we, no back-pressure
//
// a side request expands to 6 vertices, a base request to 3, a bad request to 1;
// the expander issues one vertex a cycle, unless a low vtx.ready stalls it, into
// a 22 stage pipeline (17 of them one-bit dividers) that ends at vtx.valid
// after reset and after a write to radius or height the normal-scale unit runs
// (square, setup, 29 step divide, 15 step square root); req.ready is low meanwhile
// a low vtx.ready stalls all stages while vtx.valid is high; nothing dropped or repeated
`include "cone_mesh_vertex_generator_macros.svh"

module cone_mesh_vertex_generator import cmvg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  cmvg_req_if.sink             req,
  cmvg_vtx_if.source           vtx,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------- registers
  logic [LEN_W-1:0] reg_radius;
  logic [LEN_W-1:0] reg_height;
  logic [CNT_W-1:0] reg_slices;
  logic [CNT_W-1:0] reg_stacks;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_radius <= LEN_W'(256);
      reg_height <= LEN_W'(512);
      reg_slices <= CNT_W'(16);
      reg_stacks <= CNT_W'(8);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS: reg_radius <= cfg_data;
        REG_HEIGHT: reg_height <= cfg_data;
        REG_SLICES: reg_slices <= cfg_data[CNT_W-1:0];
        REG_STACKS: reg_stacks <= cfg_data[CNT_W-1:0];
        default:    reg_radius <= reg_radius;
      endcase
    end
  end

  // counts above the limit are clamped
  logic [CNT_W-1:0] s_eff;
  logic [CNT_W-1:0] t_eff;
  assign s_eff = (reg_slices > CNT_W'(MAX_SLICES)) ? CNT_W'(MAX_SLICES) : reg_slices;
  assign t_eff = (reg_stacks > CNT_W'(MAX_STACKS)) ? CNT_W'(MAX_STACKS) : reg_stacks;

  // ------------------------------------------------------ normal-scale unit
  // c = isqrt(2^28 (R^2+H^2) / (2R^2+H^2)), ny = isqrt(2^28 R^2 / (2R^2+H^2))
  cu_state_t             cu_state;
  cu_state_t             cu_state_next;
  logic [CU_STEP_W-1:0]  cu_step;
  logic                  cu_busy;
  logic                  cu_start;
  logic                  cu_div_done;
  logic                  cu_root_done;

  logic [2*LEN_W-1:0]    rsq;
  logic [2*LEN_W-1:0]    hsq;
  logic [2*LEN_W+1:0]    bden;
  logic                  bzero;
  logic [2*LEN_W+1:0]    rem_a;
  logic [2*LEN_W+1:0]    rem_n;
  logic [CU_QUOT_W-1:0]  low_a;
  logic [CU_QUOT_W-1:0]  low_n;
  logic [CU_QUOT_W-1:0]  rv_a;
  logic [CU_QUOT_W-1:0]  rv_n;
  logic [CU_QUOT_W:0]    res_a;
  logic [CU_QUOT_W:0]    res_n;
  logic [CU_QUOT_W-1:0]  rbit;
  logic [MAG_W-1:0]      cscale;
  logic [MAG_W-1:0]      nyv;

  assign cu_start = cfg_we && (cfg_reg_t'(cfg_index) == REG_RADIUS ||
                               cfg_reg_t'(cfg_index) == REG_HEIGHT);

  always_comb begin
    cu_state_next = cu_state;
    if (cu_start) begin
      cu_state_next = CU_SQUARE;
    end else begin
      case (cu_state)
        CU_IDLE:   cu_state_next = CU_IDLE;
        CU_SQUARE: cu_state_next = CU_SETUP;
        CU_SETUP:  cu_state_next = CU_DIV;
        CU_DIV:    cu_state_next = cu_div_done ? CU_ROOT : CU_DIV;
        CU_ROOT:   cu_state_next = cu_root_done ? CU_IDLE : CU_ROOT;
        default:   cu_state_next = CU_IDLE;
      endcase
    end
  end

  always_comb begin
    cu_busy      = 1'b1;
    cu_div_done  = 1'b0;
    cu_root_done = 1'b0;
    case (cu_state)
      CU_IDLE: cu_busy = 1'b0;
      CU_DIV:  cu_div_done = (cu_step == CU_STEP_W'(CU_QUOT_W - 1));
      CU_ROOT: cu_root_done = (cu_step == CU_STEP_W'(CU_ROOT_STEPS - 1));
      default: cu_busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cu_state <= CU_SQUARE;
    end else begin
      cu_state <= cu_state_next;
    end
  end

  // divide and root step logic
  logic [2*LEN_W+2:0] ta;
  logic [2*LEN_W+2:0] tn;
  logic               ge_a;
  logic               ge_n;
  logic [CU_QUOT_W-1:0] quot_a;
  logic [CU_QUOT_W-1:0] quot_n;
  logic [CU_QUOT_W:0] sum_a;
  logic [CU_QUOT_W:0] sum_n;
  logic               rge_a;
  logic               rge_n;
  logic [CU_QUOT_W:0] res_a_next;
  logic [CU_QUOT_W:0] res_n_next;
  logic [2*LEN_W:0]   a_sum;

  always_comb begin
    a_sum  = (2*LEN_W+1)'(rsq) + (2*LEN_W+1)'(hsq);
    ta     = {rem_a, low_a[CU_QUOT_W-1]};
    tn     = {rem_n, low_n[CU_QUOT_W-1]};
    ge_a   = ta >= (2*LEN_W+3)'(bden);
    ge_n   = tn >= (2*LEN_W+3)'(bden);
    quot_a = {low_a[CU_QUOT_W-2:0], ge_a};
    quot_n = {low_n[CU_QUOT_W-2:0], ge_n};
    sum_a  = res_a + (CU_QUOT_W+1)'(rbit);
    sum_n  = res_n + (CU_QUOT_W+1)'(rbit);
    rge_a  = {1'b0, rv_a} >= sum_a;
    rge_n  = {1'b0, rv_n} >= sum_n;
    res_a_next = rge_a ? (res_a >> 1) + (CU_QUOT_W+1)'(rbit) : (res_a >> 1);
    res_n_next = rge_n ? (res_n >> 1) + (CU_QUOT_W+1)'(rbit) : (res_n >> 1);
  end

  always_ff @(posedge clk) begin
    case (cu_state)
      CU_SQUARE: begin
        rsq <= reg_radius * reg_radius;
        hsq <= reg_height * reg_height;
      end
      CU_SETUP: begin
        bden    <= ((2*LEN_W+2)'(rsq) << 1) + (2*LEN_W+2)'(hsq);
        bzero   <= (rsq == '0) && (hsq == '0);
        rem_a   <= (2*LEN_W+2)'(a_sum >> 1);
        low_a   <= {a_sum[0], (CU_QUOT_W-1)'(0)};
        rem_n   <= (2*LEN_W+2)'(rsq >> 1);
        low_n   <= {rsq[0], (CU_QUOT_W-1)'(0)};
        cu_step <= '0;
      end
      CU_DIV: begin
        rem_a   <= ge_a ? (2*LEN_W+2)'(ta - (2*LEN_W+3)'(bden)) : (2*LEN_W+2)'(ta);
        rem_n   <= ge_n ? (2*LEN_W+2)'(tn - (2*LEN_W+3)'(bden)) : (2*LEN_W+2)'(tn);
        low_a   <= quot_a;
        low_n   <= quot_n;
        cu_step <= cu_div_done ? '0 : cu_step + 1'b1;
        rv_a    <= quot_a;
        rv_n    <= quot_n;
        res_a   <= '0;
        res_n   <= '0;
        rbit    <= CU_QUOT_W'(1) << (CU_QUOT_W - 1);
      end
      CU_ROOT: begin
        rv_a    <= rge_a ? CU_QUOT_W'({1'b0, rv_a} - sum_a) : rv_a;
        rv_n    <= rge_n ? CU_QUOT_W'({1'b0, rv_n} - sum_n) : rv_n;
        res_a   <= res_a_next;
        res_n   <= res_n_next;
        rbit    <= rbit >> 2;
        cu_step <= cu_step + 1'b1;
        if (cu_root_done) begin
          // zero radius and height: normal lies in the base plane
          cscale <= bzero ? ONE_Q14 : res_a_next[MAG_W-1:0];
          nyv    <= bzero ? '0 : res_n_next[MAG_W-1:0];
        end
      end
      default: begin
        cu_step <= cu_step;
      end
    endcase
  end

  // ----------------------------------------------------------- pipeline stall
  logic o_valid;
  logic adv;
  assign adv = !o_valid || vtx.ready;

  // --------------------------------------------------------- request expander
  logic             rq_valid;
  logic             rq_func;
  logic [IDX_W-1:0] rq_k;
  logic [IDX_W-1:0] rq_m;
  logic             rq_bad;
  logic [2:0]       rq_cnt;

  vkind_t           jb_kind;
  logic             jb_last;
  logic [CNT_W-1:0] jb_a;
  logic [CNT_W-1:0] jb_l;
  logic             issue;
  logic             accept;
  logic             in_bad;

  // side cell order: (k,m+1) (k,m) (k+1,m) (k,m+1) (k+1,m) (k+1,m+1)
  always_comb begin
    jb_kind = VK_SIDE;
    jb_last = 1'b0;
    jb_a    = CNT_W'(rq_k);
    jb_l    = '0;
    if (rq_bad) begin
      jb_kind = VK_BAD;
      jb_last = 1'b1;
    end else if (!rq_func) begin
      jb_last = (rq_cnt == 3'd2);
      case (rq_cnt)
        3'd0:    jb_kind = VK_CENTRE;
        3'd1: begin
          jb_kind = VK_RIM;
          jb_a    = CNT_W'(rq_k) + 1'b1;
        end
        default: jb_kind = VK_RIM;
      endcase
    end else begin
      jb_last = (rq_cnt == 3'd5);
      if (rq_cnt inside {3'd2, 3'd4, 3'd5}) begin
        jb_a = CNT_W'(rq_k) + 1'b1;
      end
      jb_l = (rq_cnt inside {3'd0, 3'd3, 3'd5}) ? CNT_W'(rq_m) + 1'b1 : CNT_W'(rq_m);
    end
  end

  assign issue     = rq_valid && adv;
  assign req.ready = !cu_busy && !cfg_we && (!rq_valid || (adv && jb_last));
  assign accept    = req.valid && req.ready;
  assign in_bad    = (CNT_W'(req.slice_index) >= s_eff) ||
                     (req.func && (CNT_W'(req.stack_index) >= t_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid <= 1'b0;
    end else if (accept) begin
      rq_valid <= 1'b1;
    end else if (issue && jb_last) begin
      rq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_func <= req.func;
      rq_k    <= req.slice_index;
      rq_m    <= req.stack_index;
      rq_bad  <= in_bad;
      rq_cnt  <= '0;
    end else if (issue) begin
      rq_cnt  <= rq_cnt + 1'b1;
    end
  end

  // ------------------------------------------------------- stage 1: job word
  logic             p1_valid;
  vkind_t           p1_kind;
  logic             p1_last;
  logic [CNT_W-1:0] p1_a;
  logic [CNT_W-1:0] p1_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind <= jb_kind;
      p1_last <= jb_last;
      p1_a    <= jb_a;
      p1_l    <= jb_l;
    end
  end

  // ---------------------------------------- stage 2 and divider bit stages
  // phase (= tex_u) over S; tex_v term, height and ring radius over T
  typedef struct packed {
    vkind_t    kind;
    logic      last;
    div_lane_t ph;
    div_lane_t tq;
    div_lane_t py;
    div_lane_t rr;
  } dv_t;

  dv_t  dv       [DIV_STEPS+1];
  logic dv_valid [DIV_STEPS+1];

  logic [DIV_NUM_W-1:0] n_ph;
  logic [DIV_NUM_W-1:0] n_tq;
  logic [DIV_NUM_W-1:0] n_py;
  logic [DIV_NUM_W-1:0] n_rr;

  always_comb begin
    n_ph = (DIV_NUM_W'(p1_a) << ANGLE_BITS) + DIV_NUM_W'(s_eff >> 1);
    n_tq = (DIV_NUM_W'(p1_l) << ANGLE_BITS) + DIV_NUM_W'(t_eff >> 1);
    n_py = DIV_NUM_W'(reg_height) * DIV_NUM_W'(p1_l) + DIV_NUM_W'(t_eff >> 1);
    n_rr = DIV_NUM_W'(reg_radius) * DIV_NUM_W'(CNT_W'(t_eff - p1_l)) +
           DIV_NUM_W'(t_eff >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].kind <= p1_kind;
      dv[0].last <= p1_last;
      dv[0].ph   <= div_init(n_ph);
      dv[0].tq   <= div_init(n_tq);
      dv[0].py   <= div_init(n_py);
      dv[0].rr   <= div_init(n_rr);
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[g+1].kind <= dv[g].kind;
        dv[g+1].last <= dv[g].last;
        dv[g+1].ph   <= div_step(dv[g].ph, s_eff);
        dv[g+1].tq   <= div_step(dv[g].tq, t_eff);
        dv[g+1].py   <= div_step(dv[g].py, t_eff);
        dv[g+1].rr   <= div_step(dv[g].rr, t_eff);
      end
    end
  end

  // ------------------------------------------------- sine and cosine lookup
  logic             lk_valid;
  vkind_t           lk_kind;
  logic             lk_last;
  sine_t            lk_sin;
  sine_t            lk_cos;
  logic [TEX_W-1:0] lk_tu;
  logic [TEX_W-1:0] lk_tv;
  logic [LEN_W-1:0] lk_py;
  logic [LEN_W-1:0] lk_r;
  logic [ANGLE_BITS-1:0] phase;

  // a full turn wraps to zero
  assign phase = dv[DIV_STEPS].ph.w[ANGLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_valid <= 1'b0;
    end else if (adv) begin
      lk_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lk_kind <= dv[DIV_STEPS].kind;
      lk_last <= dv[DIV_STEPS].last;
      lk_sin  <= sine_of(phase);
      lk_cos  <= sine_of(ANGLE_BITS'(phase + QUARTER_TURN));
      lk_tu   <= dv[DIV_STEPS].ph.w;
      lk_tv   <= TEX_ONE - dv[DIV_STEPS].tq.w;
      lk_py   <= dv[DIV_STEPS].py.w[LEN_W-1:0];
      // rims sit on the base radius whatever the stack count, even zero
      lk_r    <= (dv[DIV_STEPS].kind == VK_RIM) ? reg_radius :
                 dv[DIV_STEPS].rr.w[LEN_W-1:0];
    end
  end

  // ------------------------------------------------------- scale multipliers
  localparam int PROD_W = MAG_W + LEN_W;

  logic             m_valid;
  vkind_t           m_kind;
  logic             m_last;
  logic             m_sneg;
  logic             m_cneg;
  logic [LEN_W-1:0] m_px;
  logic [LEN_W-1:0] m_pz;
  logic [MAG_W-1:0] m_nx;
  logic [MAG_W-1:0] m_nz;
  logic [TEX_W-1:0] m_tu;
  logic [TEX_W-1:0] m_tv;
  logic [LEN_W-1:0] m_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= lk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_kind <= lk_kind;
      m_last <= lk_last;
      m_sneg <= lk_sin.neg;
      m_cneg <= lk_cos.neg;
      m_px   <= LEN_W'((PROD_W'(lk_sin.mag) * PROD_W'(lk_r) +
                        PROD_W'(1 << (NORM_FRAC - 1))) >> NORM_FRAC);
      m_pz   <= LEN_W'((PROD_W'(lk_cos.mag) * PROD_W'(lk_r) +
                        PROD_W'(1 << (NORM_FRAC - 1))) >> NORM_FRAC);
      m_nx   <= MAG_W'((PROD_W'(lk_sin.mag) * PROD_W'(cscale) +
                        PROD_W'(1 << (NORM_FRAC - 1))) >> NORM_FRAC);
      m_nz   <= MAG_W'((PROD_W'(lk_cos.mag) * PROD_W'(cscale) +
                        PROD_W'(1 << (NORM_FRAC - 1))) >> NORM_FRAC);
      m_tu   <= lk_tu;
      m_tv   <= lk_tv;
      m_py   <= lk_py;
    end
  end

  // ----------------------------------------------------- output word register
  logic signed [LEN_W:0] px_s;
  logic signed [LEN_W:0] pz_s;
  logic signed [15:0]    nx_s;
  logic signed [15:0]    nz_s;

  logic signed [LEN_W:0] o_pos_x;
  logic [LEN_W-1:0]      o_pos_y;
  logic signed [LEN_W:0] o_pos_z;
  logic signed [15:0]    o_norm_x;
  logic signed [15:0]    o_norm_y;
  logic signed [15:0]    o_norm_z;
  logic [TEX_W-1:0]      o_tex_u;
  logic [TEX_W-1:0]      o_tex_v;
  logic                  o_bad;
  logic                  o_last;

  always_comb begin
    px_s = m_sneg ? -$signed({1'b0, m_px}) : $signed({1'b0, m_px});
    pz_s = m_cneg ? -$signed({1'b0, m_pz}) : $signed({1'b0, m_pz});
    nx_s = m_sneg ? -$signed({1'b0, m_nx}) : $signed({1'b0, m_nx});
    nz_s = m_cneg ? -$signed({1'b0, m_nz}) : $signed({1'b0, m_nz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_last <= m_last;
      case (m_kind)
        VK_SIDE: begin
          o_pos_x  <= px_s;
          o_pos_y  <= m_py;
          o_pos_z  <= pz_s;
          o_norm_x <= nx_s;
          o_norm_y <= $signed({1'b0, nyv});
          o_norm_z <= nz_s;
          o_tex_u  <= m_tu;
          o_tex_v  <= m_tv;
          o_bad    <= 1'b0;
        end
        VK_RIM: begin
          o_pos_x  <= px_s;
          o_pos_y  <= '0;
          o_pos_z  <= pz_s;
          o_norm_x <= '0;
          o_norm_y <= NORM_DOWN;
          o_norm_z <= '0;
          o_tex_u  <= TEX_HALF;
          o_tex_v  <= '0;
          o_bad    <= 1'b0;
        end
        VK_CENTRE: begin
          o_pos_x  <= '0;
          o_pos_y  <= '0;
          o_pos_z  <= '0;
          o_norm_x <= '0;
          o_norm_y <= NORM_DOWN;
          o_norm_z <= '0;
          o_tex_u  <= TEX_HALF;
          o_tex_v  <= '0;
          o_bad    <= 1'b0;
        end
        default: begin
          // out-of-range request: one all-zero flagged word
          o_pos_x  <= '0;
          o_pos_y  <= '0;
          o_pos_z  <= '0;
          o_norm_x <= '0;
          o_norm_y <= '0;
          o_norm_z <= '0;
          o_tex_u  <= '0;
          o_tex_v  <= '0;
          o_bad    <= 1'b1;
        end
      endcase
    end
  end

  assign vtx.valid       = o_valid;
  assign vtx.pos_x       = o_pos_x;
  assign vtx.pos_y       = o_pos_y;
  assign vtx.pos_z       = o_pos_z;
  assign vtx.norm_x      = o_norm_x;
  assign vtx.norm_y      = o_norm_y;
  assign vtx.norm_z      = o_norm_z;
  assign vtx.tex_u       = o_tex_u;
  assign vtx.tex_v       = o_tex_v;
  assign vtx.bad_index   = o_bad;
  assign vtx.last_vertex = o_last;

  // --------------------------------------------------------------- checks
  `CMVG_ASSERT_NOW(a_no_accept_busy, clk, rst, req.valid && req.ready, !cu_busy,
                   "request taken while normal scale recomputes")
  `CMVG_ASSERT_NEXT(a_recompute_start, clk, rst, cu_start, cu_busy,
                    "radius or height write did not restart normal scale")
  `CMVG_ASSERT_NOW(a_bad_word, clk, rst, vtx.valid && vtx.bad_index,
                   vtx.last_vertex && vtx.pos_x == '0 && vtx.tex_u == '0,
                   "flagged word not single or not cleared")

endmodule
